/* sv/clock_synth_divider_planner_defines.svh */
// Assertion helpers for the planner modules; cspl_emit is the one that uses them.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef CLOCK_SYNTH_DIVIDER_PLANNER_DEFINES_SVH
`define CLOCK_SYNTH_DIVIDER_PLANNER_DEFINES_SVH

// Same-cycle implication.
`define CSPL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("planner check failed");

// Next-cycle implication.
`define CSPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("planner check failed");

`endif

/* sv/cspl_pkg.sv */
package cspl_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_FREQUENCY        = 3'd0;
    localparam logic [2:0] CFG_MAX_FREQUENCY        = 3'd1;
    localparam logic [2:0] CFG_TIMER_SOURCE_MODE    = 3'd2;
    localparam logic [2:0] CFG_PLL_TARGET           = 3'd3;
    localparam logic [2:0] CFG_REF_CLK_FREQ         = 3'd4;
    localparam logic [2:0] CFG_FRACTION_DENOMINATOR = 3'd5;

    localparam logic [19:0] MIN_FREQUENCY_RST        = 20'd450;
    localparam logic [19:0] MAX_FREQUENCY_RST        = 20'd1300;
    localparam logic [23:0] PLL_TARGET_RST           = 24'd900000;
    localparam logic [23:0] REF_CLK_FREQ_RST         = 24'd25000;
    localparam logic [19:0] FRACTION_DENOMINATOR_RST = 20'hFFFFF;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHAN_ERR = 2'd1;
    localparam logic [1:0] STATUS_FREQ_ERR = 2'd2;

    // Chip register map.
    localparam logic [7:0] ADDR_PLL_A     = 8'd26;
    localparam logic [7:0] ADDR_MS_0      = 8'd42;
    localparam logic [7:0] ADDR_MS_1      = 8'd50;
    localparam logic [7:0] ADDR_PLL_RESET = 8'd177;
    localparam logic [7:0] ADDR_CLK0_CTRL = 8'd16;
    localparam logic [7:0] ADDR_CLK1_CTRL = 8'd17;
    localparam logic [7:0] VAL_PLL_RESET  = 8'hA0;
    localparam logic [7:0] VAL_CLK_CTRL   = 8'h4F;

    // Beat positions within one request's run.
    localparam logic [4:0] IDX_MS_FIRST  = 5'd8;
    localparam logic [4:0] IDX_PLL_RESET = 5'd16;
    localparam logic [4:0] IDX_CLK_CTRL  = 5'd17;

    localparam logic [17:0] P1_OFFSET = 18'd512;

    // Divider passes, counted in 4-bit quotient digits.
    localparam int         DIGIT_BITS  = 4;
    localparam logic [2:0] DIGITS_FULL = 3'd6;
    localparam logic [2:0] DIGITS_NUM  = 3'd5;
    localparam logic [2:0] DIGITS_T    = 3'd2;

    typedef struct packed {
        logic [1:0]  channel;
        logic [19:0] frequency;
    } req_t;

    typedef struct packed {
        logic        write_valid;
        logic [7:0]  reg_address;
        logic [7:0]  reg_value;
        logic [1:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [19:0] min_frequency;
        logic [19:0] max_frequency;
        logic        timer_source_mode;
        logic [23:0] pll_target;
        logic [23:0] ref_clk_freq;
        logic [19:0] fraction_denominator;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_OK,
        KIND_CHAN_ERR,
        KIND_FREQ_ERR
    } kind_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        kind_t       kind;
        logic        ms_sel;
        logic [20:0] freq;
    } entry_t;

    // Everything the emitter needs to produce one run of beats.
    typedef struct packed {
        kind_t       kind;
        logic        ms_sel;
        logic [17:0] pll_p1;
        logic [19:0] pll_p2;
        logic [19:0] pll_p3;
        logic [17:0] ms_p1;
    } plan_t;

    typedef struct packed {
        logic        start;
        logic [2:0]  digits;
        logic [23:0] r_init;
        logic [23:0] low;
        logic [23:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
        logic [23:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DIV1,
        CS_VCO,
        CS_DIV3,
        CS_PROD,
        CS_DIV4,
        CS_TSTART,
        CS_DIV5,
        CS_PARAMS,
        CS_HOLD
    } comp_state_t;

    // Byte k of an eight-register P1/P2/P3 parameter block.
    function automatic logic [7:0] param_byte(input logic [2:0]  k,
                                              input logic [17:0] p1,
                                              input logic [19:0] p2,
                                              input logic [19:0] p3);
        logic [7:0] b;
        case (k)
            3'd0:    b = p3[15:8];
            3'd1:    b = p3[7:0];
            3'd2:    b = {6'd0, p1[17:16]};
            3'd3:    b = p1[15:8];
            3'd4:    b = p1[7:0];
            3'd5:    b = {p3[19:16], p2[19:16]};
            3'd6:    b = p2[15:8];
            default: b = p2[7:0];
        endcase
        return b;
    endfunction

endpackage

/* sv/cspl_front.sv */
module cspl_front
    import cspl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        req_valid,
    input  req_t        req_data,
    output logic        req_stall,
    input  logic        q_full,
    output logic        push,
    output entry_t      push_entry,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic freq_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_frequency        <= MIN_FREQUENCY_RST;
            cfg_reg.max_frequency        <= MAX_FREQUENCY_RST;
            cfg_reg.timer_source_mode    <= 1'b0;
            cfg_reg.pll_target           <= PLL_TARGET_RST;
            cfg_reg.ref_clk_freq         <= REF_CLK_FREQ_RST;
            cfg_reg.fraction_denominator <= FRACTION_DENOMINATOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_FREQUENCY:        cfg_reg.min_frequency <= cfg_data[19:0];
                CFG_MAX_FREQUENCY:        cfg_reg.max_frequency <= cfg_data[19:0];
                CFG_TIMER_SOURCE_MODE:    cfg_reg.timer_source_mode <= cfg_data[0];
                CFG_PLL_TARGET:           cfg_reg.pll_target <= cfg_data;
                CFG_REF_CLK_FREQ:         cfg_reg.ref_clk_freq <= cfg_data;
                CFG_FRACTION_DENOMINATOR: cfg_reg.fraction_denominator <= cfg_data[19:0];
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    always_comb
    begin
        freq_bad = (req_data.frequency == 20'd0)
                || (req_data.frequency < cfg_reg.min_frequency)
                || (req_data.frequency > cfg_reg.max_frequency);

        if (freq_bad)
            push_entry.kind = KIND_FREQ_ERR;
        else if (req_data.channel[1])
            push_entry.kind = KIND_CHAN_ERR;
        else
            push_entry.kind = KIND_OK;

        push_entry.ms_sel = req_data.channel[0];
        push_entry.freq   = cfg_reg.timer_source_mode ? {req_data.frequency, 1'b0}
                                                      : {1'b0, req_data.frequency};
    end

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

endmodule

/* sv/cspl_fifo.sv */
module cspl_fifo
    import cspl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   head_valid,
    output entry_t head_entry,
    input  logic   pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* sv/cspl_div.sv */
module cspl_div
    import cspl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    // Restoring divider, four quotient bits per cycle. The partial remainder
    // starts below the divisor, so the quotient fits in the digits asked for.
    logic [23:0] r_reg;
    logic [23:0] low_reg;
    logic [23:0] q_reg;
    logic [23:0] d_reg;
    logic [2:0]  cnt_reg;
    logic        done_reg;

    logic [24:0] r_w;
    logic [23:0] low_w;
    logic [23:0] q_w;

    always_comb
    begin
        r_w   = {1'b0, r_reg};
        low_w = low_reg;
        q_w   = q_reg;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            r_w   = {r_w[23:0], low_w[23]};
            low_w = {low_w[22:0], 1'b0};
            if (r_w >= {1'b0, d_reg})
            begin
                r_w = r_w - {1'b0, d_reg};
                q_w = {q_w[22:0], 1'b1};
            end
            else
            begin
                q_w = {q_w[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 3'd1);
            if (cmd.start)
                cnt_reg <= cmd.digits;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_reg   <= cmd.r_init;
            low_reg <= cmd.low;
            q_reg   <= '0;
            d_reg   <= cmd.divisor;
        end
        else if (cnt_reg != '0)
        begin
            r_reg   <= r_w[23:0];
            low_reg <= low_w;
            q_reg   <= q_w;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

/* sv/cspl_back.sv */
module cspl_back
    import cspl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   head_valid,
    input  entry_t head_entry,
    output logic   pop,
    output logic   plan_valid,
    output plan_t  plan,
    input  logic   plan_ready
);

    comp_state_t state_reg;
    comp_state_t state_next;
    entry_t      ent_reg;
    logic [23:0] divider_reg;
    logic [7:0]  mult_reg;
    logic [23:0] rem_reg;
    logic [19:0] num_reg;
    logic [6:0]  t_reg;
    plan_t       plan_reg;

    div_cmd_t    cmd;
    div_rsp_t    rsp;
    logic        frac_off;
    logic        xtal_zero;
    logic [44:0] vco_full;
    logic [43:0] prod;
    logic [26:0] ct;

    cspl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign xtal_zero = (cfg.ref_clk_freq == 24'd0);
    // With no crystal or no denominator the fractional part is forced to zero.
    assign frac_off  = xtal_zero || (cfg.fraction_denominator == 20'd0);
    assign vco_full  = divider_reg * ent_reg.freq;
    assign prod      = rem_reg * cfg.fraction_denominator;
    assign ct        = cfg.fraction_denominator * t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_entry.kind == KIND_FREQ_ERR)
                        state_next = CS_HOLD;
                    else
                    begin
                        cmd.start   = 1'b1;
                        cmd.digits  = DIGITS_FULL;
                        cmd.low     = cfg.pll_target;
                        cmd.divisor = {3'd0, head_entry.freq};
                        state_next  = CS_DIV1;
                    end
                end
            end
            CS_DIV1:
            begin
                if (rsp.done)
                    state_next = CS_VCO;
            end
            CS_VCO:
            begin
                // The product never exceeds the PLL target, so 24 bits hold it.
                cmd.start   = 1'b1;
                cmd.digits  = DIGITS_FULL;
                cmd.low     = vco_full[23:0];
                cmd.divisor = cfg.ref_clk_freq;
                state_next  = CS_DIV3;
            end
            CS_DIV3:
            begin
                if (rsp.done)
                    state_next = CS_PROD;
            end
            CS_PROD:
            begin
                cmd.start   = 1'b1;
                cmd.digits  = DIGITS_NUM;
                cmd.r_init  = prod[43:20];
                cmd.low     = {prod[19:0], 4'd0};
                cmd.divisor = cfg.ref_clk_freq;
                state_next  = CS_DIV4;
            end
            CS_DIV4:
            begin
                if (rsp.done)
                    state_next = CS_TSTART;
            end
            CS_TSTART:
            begin
                // 128 * num over c, taken as an eight-bit quotient.
                cmd.start   = 1'b1;
                cmd.digits  = DIGITS_T;
                cmd.r_init  = {5'd0, num_reg[19:1]};
                cmd.low     = {num_reg[0], 23'd0};
                cmd.divisor = {4'd0, cfg.fraction_denominator};
                state_next  = CS_DIV5;
            end
            CS_DIV5:
            begin
                if (rsp.done)
                    state_next = CS_PARAMS;
            end
            CS_PARAMS:
            begin
                state_next = CS_HOLD;
            end
            CS_HOLD:
            begin
                if (plan_ready)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CS_IDLE && head_valid)
        begin
            ent_reg       <= head_entry;
            plan_reg.kind <= head_entry.kind;
        end
        if (state_reg == CS_DIV1 && rsp.done)
            divider_reg <= {rsp.quotient[23:1], 1'b0};
        if (state_reg == CS_DIV3 && rsp.done)
        begin
            mult_reg <= xtal_zero ? 8'd0 : rsp.quotient[7:0];
            rem_reg  <= xtal_zero ? 24'd0 : rsp.remainder;
        end
        if (state_reg == CS_DIV4 && rsp.done)
            num_reg <= frac_off ? 20'd0 : rsp.quotient[19:0];
        if (state_reg == CS_DIV5 && rsp.done)
            t_reg <= frac_off ? 7'd0 : rsp.quotient[6:0];
        if (state_reg == CS_PARAMS)
        begin
            plan_reg.kind   <= ent_reg.kind;
            plan_reg.ms_sel <= ent_reg.ms_sel;
            plan_reg.pll_p1 <= {3'd0, mult_reg, 7'd0} + {11'd0, t_reg} - P1_OFFSET;
            plan_reg.pll_p2 <= {num_reg[12:0], 7'd0} - ct[19:0];
            plan_reg.pll_p3 <= cfg.fraction_denominator;
            plan_reg.ms_p1  <= {divider_reg[10:0], 7'd0} - P1_OFFSET;
        end
    end

    assign plan_valid = (state_reg == CS_HOLD);
    assign plan       = plan_reg;

endmodule

/* sv/cspl_emit.sv */
`include "clock_synth_divider_planner_defines.svh"

module cspl_emit
    import cspl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  plan_valid,
    input  plan_t plan,
    output logic  plan_ready,
    output logic  res_valid,
    output res_t  res_data,
    input  logic  res_stall
);

    logic       active_reg;
    logic [4:0] idx_reg;
    plan_t      cur_reg;

    res_t       beat;
    logic       beat_take;
    logic       load;

    always_comb
    begin
        beat = '0;
        unique case (cur_reg.kind) inside
            KIND_FREQ_ERR:
            begin
                beat.status = STATUS_FREQ_ERR;
                beat.last   = 1'b1;
            end
            KIND_OK, KIND_CHAN_ERR:
            begin
                if (idx_reg < IDX_MS_FIRST)
                begin
                    beat.write_valid = 1'b1;
                    beat.reg_address = ADDR_PLL_A + {5'd0, idx_reg[2:0]};
                    beat.reg_value   = param_byte(idx_reg[2:0], cur_reg.pll_p1,
                                                  cur_reg.pll_p2, cur_reg.pll_p3);
                end
                else if (cur_reg.kind == KIND_CHAN_ERR)
                begin
                    beat.status = STATUS_CHAN_ERR;
                    beat.last   = 1'b1;
                end
                else if (idx_reg < IDX_PLL_RESET)
                begin
                    beat.write_valid = 1'b1;
                    beat.reg_address = (cur_reg.ms_sel ? ADDR_MS_1 : ADDR_MS_0)
                                     + {5'd0, idx_reg[2:0]};
                    beat.reg_value   = param_byte(idx_reg[2:0], cur_reg.ms_p1,
                                                  20'd0, 20'd1);
                end
                else if (idx_reg == IDX_PLL_RESET)
                begin
                    beat.write_valid = 1'b1;
                    beat.reg_address = ADDR_PLL_RESET;
                    beat.reg_value   = VAL_PLL_RESET;
                end
                else
                begin
                    beat.write_valid = 1'b1;
                    beat.reg_address = cur_reg.ms_sel ? ADDR_CLK1_CTRL : ADDR_CLK0_CTRL;
                    beat.reg_value   = VAL_CLK_CTRL;
                    beat.last        = 1'b1;
                end
            end
            default:
            begin
                beat = '0;
            end
        endcase
    end

    assign beat_take  = active_reg && !res_stall;
    // A new plan loads while the final beat of the current run goes out.
    assign plan_ready = !active_reg || (beat_take && beat.last);
    assign load       = plan_valid && plan_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (beat_take)
        begin
            if (beat.last)
                active_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= plan;
    end

    assign res_valid = active_reg;
    assign res_data  = beat;

    `CSPL_ASSERT_NEXT(a_run_continues, beat_take && !beat.last, active_reg)
    `CSPL_ASSERT_IMPL(a_idx_bound, active_reg, idx_reg <= IDX_CLK_CTRL)
    `CSPL_ASSERT_IMPL(a_error_beat, active_reg && beat.status != STATUS_OK, !beat.write_valid && beat.last)

endmodule

/* sv/clock_synth_divider_planner.sv */
// Channel   Handshake               Payload
// req       req_valid / req_stall   req_t: channel, frequency
// res       res_valid / res_stall   res_t: write_valid, reg_address, reg_value, status, last
// cfg       cfg_write               cfg_index selects the register, cfg_data carries it
//
// A planned request runs through the compute sequencer: four passes of the shared
// 4-bit-per-cycle divider plus setup steps. Its 18 beats go out while the next
// request is computed, so the sequencer takes the next request while the emitter
// still sends this run; a frequency error skips the divider passes.
// Reset clears the queue, the sequencer and the emitter, and loads register defaults.
// A stall on res holds the current beat; the queue fills and then stalls req.
module clock_synth_divider_planner
    import cspl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        req_valid,
    input  req_t        req_data,
    output logic        req_stall,
    output logic        res_valid,
    output res_t        res_data,
    input  logic        res_stall
);

    cfg_t   cfg;
    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   head_valid;
    entry_t head_entry;
    logic   pop;
    logic   plan_valid;
    plan_t  plan;
    logic   plan_ready;

    cspl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_data   (req_data),
        .req_stall  (req_stall),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .cfg        (cfg)
    );

    cspl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    cspl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_ready (plan_ready)
    );

    cspl_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_ready (plan_ready),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_stall  (res_stall)
    );

endmodule
